### src/r2p_pkg.sv
// ----------------------------------------------------------------------------
// r2p_pkg: shared types and microcode for the RGB565 to PPM stream encoder
// Control word layout, datapath codes and the microcode ROM.
// ----------------------------------------------------------------------------
package r2p_pkg;

   localparam int DIM_BITS   = 16;
   localparam int COUNT_BITS = 2 * DIM_BITS;
   localparam int DEC_DIGITS = 5;
   localparam int DIG_BITS   = $clog2(DEC_DIGITS);
   localparam int CNT_BITS   = $clog2(DIM_BITS + 1);
   localparam int PC_BITS    = 5;

   // byte source
   localparam logic [2:0] SRC_CONST = 3'd0;
   localparam logic [2:0] SRC_DIGIT = 3'd1;
   localparam logic [2:0] SRC_RED   = 3'd2;
   localparam logic [2:0] SRC_GREEN = 3'd3;
   localparam logic [2:0] SRC_BLUE  = 3'd4;

   // datapath operation
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_LOAD_W   = 3'd1;
   localparam logic [2:0] OP_LOAD_H   = 3'd2;
   localparam logic [2:0] OP_DABBLE   = 3'd3;
   localparam logic [2:0] OP_DIG_NEXT = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;
   localparam logic [2:0] OP_PIX_DEC  = 3'd6;

   // jump condition
   localparam logic [1:0] COND_NONE = 2'd0;
   localparam logic [1:0] COND_BAD  = 2'd1;
   localparam logic [1:0] COND_CONV = 2'd2;
   localparam logic [1:0] COND_DIG  = 2'd3;

   // program addresses
   localparam logic [PC_BITS-1:0] PC_HDR    = 5'd0;
   localparam logic [PC_BITS-1:0] PC_CONV_W = 5'd4;
   localparam logic [PC_BITS-1:0] PC_DIG_W  = 5'd5;
   localparam logic [PC_BITS-1:0] PC_CONV_H = 5'd7;
   localparam logic [PC_BITS-1:0] PC_DIG_H  = 5'd8;
   localparam logic [PC_BITS-1:0] PC_ERR    = 5'd14;
   localparam logic [PC_BITS-1:0] PC_PIX    = 5'd15;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic               emit;
      logic [2:0]         src;
      logic [7:0]         chr;
      logic               status;
      logic               last;
      logic [2:0]         op;
      logic [1:0]         cond;
      logic [PC_BITS-1:0] target;
      logic               fin;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode(input logic [PC_BITS-1:0] pc);
      ctrl_word_type cw;
      cw = '{emit: 1'b0, src: SRC_CONST, chr: 8'h00, status: 1'b0, last: 1'b0,
             op: OP_NONE, cond: COND_NONE, target: PC_HDR, fin: 1'b0};
      case (pc)
         5'd0: begin
            cw.op     = OP_LOAD_W;
            cw.cond   = COND_BAD;
            cw.target = PC_ERR;
         end
         5'd1: begin cw.emit = 1'b1; cw.chr = "P"; end
         5'd2: begin cw.emit = 1'b1; cw.chr = "6"; end
         5'd3: begin cw.emit = 1'b1; cw.chr = 8'h0A; end
         5'd4: begin
            cw.op     = OP_DABBLE;
            cw.cond   = COND_CONV;
            cw.target = PC_CONV_W;
         end
         5'd5: begin
            cw.emit   = 1'b1;
            cw.src    = SRC_DIGIT;
            cw.op     = OP_DIG_NEXT;
            cw.cond   = COND_DIG;
            cw.target = PC_DIG_W;
         end
         5'd6: begin cw.emit = 1'b1; cw.chr = " "; cw.op = OP_LOAD_H; end
         5'd7: begin
            cw.op     = OP_DABBLE;
            cw.cond   = COND_CONV;
            cw.target = PC_CONV_H;
         end
         5'd8: begin
            cw.emit   = 1'b1;
            cw.src    = SRC_DIGIT;
            cw.op     = OP_DIG_NEXT;
            cw.cond   = COND_DIG;
            cw.target = PC_DIG_H;
         end
         5'd9:  begin cw.emit = 1'b1; cw.chr = 8'h0A; end
         5'd10: begin cw.emit = 1'b1; cw.chr = "2"; end
         5'd11: begin cw.emit = 1'b1; cw.chr = "5"; end
         5'd12: begin cw.emit = 1'b1; cw.chr = "5"; end
         5'd13: begin cw.emit = 1'b1; cw.chr = 8'h0A; cw.last = 1'b1; cw.fin = 1'b1; end
         5'd14: begin
            cw.emit   = 1'b1;
            cw.status = 1'b1;
            cw.last   = 1'b1;
            cw.op     = OP_CLEAR;
            cw.fin    = 1'b1;
         end
         5'd15: begin cw.emit = 1'b1; cw.src = SRC_RED; end
         5'd16: begin cw.emit = 1'b1; cw.src = SRC_GREEN; end
         5'd17: begin
            cw.emit = 1'b1;
            cw.src  = SRC_BLUE;
            cw.last = 1'b1;
            cw.op   = OP_PIX_DEC;
            cw.fin  = 1'b1;
         end
         default: begin
            cw.fin = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

### src/rgb565_to_ppm_stream.sv
// ----------------------------------------------------------------------------
// rgb565_to_ppm_stream: RGB565 pixel stream to binary PPM (P6) byte stream
// A microcoded sequencer emits the header (decimal via double dabble) and
// expands each pixel in an open frame into three bytes R, G, B.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | kind, pixel_word
//  rsp     | out       | rsp_valid/stall    | out_byte, status, run_last, frame_done
//  csr     | in        | csr_wen            | csr_index, csr_wdata
//
//  Pixel transaction: accept plus one microcode step per byte.
//  Start transaction: accept, size check, two 16-step dabble loops,
//  five digit steps per number and one step per fixed header byte.
//  Start with zero width or height: accept, size check, one status byte. Dropped pixels do not start the sequencer.
//  Reset is synchronous; it clears the sequencer, frame state and output valid.
//  Output stall with a byte pending freezes the sequencer on any byte-emitting step.
// ----------------------------------------------------------------------------
module rgb565_to_ppm_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_pixel_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_status,
   output logic        rsp_run_last,
   output logic        rsp_frame_done,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [r2p_pkg::DIM_BITS-1:0]   width_ff, width_in;
   logic [r2p_pkg::DIM_BITS-1:0]   height_ff, height_in;
   logic [r2p_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic                           open_ff, open_in;
   logic                           busy_ff, busy_in;
   logic [r2p_pkg::PC_BITS-1:0]    pc_ff, pc_in;
   logic [15:0]                    pix_ff, pix_in;
   logic [r2p_pkg::DIM_BITS-1:0]   bin_ff, bin_in;
   logic [r2p_pkg::DEC_DIGITS-1:0][3:0] bcd_ff, bcd_in;
   logic [r2p_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [r2p_pkg::DIG_BITS-1:0]   dig_ff, dig_in;
   logic                           lead_ff, lead_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           status_ff, status_in;
   logic                           last_ff, last_in;
   logic                           done_ff, done_in;

   r2p_pkg::ctrl_word_type         cw;
   logic                           req_take;
   logic                           out_free;
   logic                           emit_now;
   logic                           step_go;
   logic                           cond_hit;
   logic [3:0]                     cur_digit;
   logic                           digit_show;
   logic [r2p_pkg::DEC_DIGITS-1:0][3:0] bcd_adj;
   logic [7:0]                     sel_byte;

   assign req_stall      = busy_ff;
   assign req_take       = req_valid && !busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_status     = status_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_frame_done = done_ff;

   assign cw         = r2p_pkg::ucode(pc_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_digit  = bcd_ff[dig_ff];
   assign digit_show = (cur_digit != 4'd0) || lead_ff || (dig_ff == '0);
   assign emit_now   = busy_ff && cw.emit &&
                       ((cw.src != r2p_pkg::SRC_DIGIT) || digit_show);
   assign step_go    = busy_ff && (!emit_now || out_free);

   always_comb begin
      for (int i = 0; i < r2p_pkg::DEC_DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      case (cw.cond)
         r2p_pkg::COND_BAD:  cond_hit = (width_ff == '0) || (height_ff == '0);
         r2p_pkg::COND_CONV: cond_hit = (cnt_ff != r2p_pkg::CNT_BITS'(1));
         r2p_pkg::COND_DIG:  cond_hit = (dig_ff != '0);
         default:            cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.src)
         r2p_pkg::SRC_DIGIT: sel_byte = {4'h3, cur_digit};
         r2p_pkg::SRC_RED:   sel_byte = {pix_ff[15:11], pix_ff[15:13]};
         r2p_pkg::SRC_GREEN: sel_byte = {pix_ff[10:5], pix_ff[10:9]};
         r2p_pkg::SRC_BLUE:  sel_byte = {pix_ff[4:0], pix_ff[4:2]};
         default:            sel_byte = cw.chr;
      endcase
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      left_in      = left_ff;
      open_in      = open_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      pix_in       = pix_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      lead_in      = lead_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      done_in      = done_ff;

      if (csr_wen) begin
         case (csr_index)
            r2p_pkg::CSR_WIDTH:  width_in  = csr_wdata[r2p_pkg::DIM_BITS-1:0];
            r2p_pkg::CSR_HEIGHT: height_in = csr_wdata[r2p_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end

      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_take) begin
         pix_in = req_pixel_word;
         if (!req_kind) begin
            busy_in = 1'b1;
            pc_in   = r2p_pkg::PC_HDR;
         end else if (open_ff && (left_ff != '0)) begin
            busy_in = 1'b1;
            pc_in   = r2p_pkg::PC_PIX;
         end else begin
            open_in = 1'b0;
         end
      end

      if (step_go) begin
         if (emit_now) begin
            rsp_valid_in = 1'b1;
            byte_in      = (cw.status) ? 8'h00 : sel_byte;
            status_in    = cw.status;
            last_in      = cw.last;
            done_in      = (cw.src == r2p_pkg::SRC_BLUE) &&
                           (left_ff == r2p_pkg::COUNT_BITS'(1));
         end

         case (cw.op)
            r2p_pkg::OP_LOAD_W, r2p_pkg::OP_LOAD_H: begin
               bin_in  = (cw.op == r2p_pkg::OP_LOAD_W) ? width_ff : height_ff;
               bcd_in  = '0;
               cnt_in  = r2p_pkg::CNT_BITS'(r2p_pkg::DIM_BITS);
               dig_in  = r2p_pkg::DIG_BITS'(r2p_pkg::DEC_DIGITS - 1);
               lead_in = 1'b0;
               if (cw.op == r2p_pkg::OP_LOAD_W) begin
                  left_in = width_ff * height_ff;
                  open_in = 1'b1;
               end
            end
            r2p_pkg::OP_DABBLE: begin
               {bcd_in, bin_in} = {bcd_adj, bin_ff} << 1;
               cnt_in           = cnt_ff - r2p_pkg::CNT_BITS'(1);
            end
            r2p_pkg::OP_DIG_NEXT: begin
               lead_in = lead_ff || (cur_digit != 4'd0);
               dig_in  = dig_ff - r2p_pkg::DIG_BITS'(1);
            end
            r2p_pkg::OP_CLEAR: begin
               left_in = '0;
               open_in = 1'b0;
            end
            r2p_pkg::OP_PIX_DEC: begin
               left_in = left_ff - r2p_pkg::COUNT_BITS'(1);
               if (left_ff == r2p_pkg::COUNT_BITS'(1)) begin
                  open_in = 1'b0;
               end
            end
            default: ;
         endcase

         if (cw.fin) begin
            busy_in = 1'b0;
         end else if (cond_hit) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + r2p_pkg::PC_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= r2p_pkg::DIM_BITS'(1);
         height_ff    <= r2p_pkg::DIM_BITS'(1);
         left_ff      <= '0;
         open_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= r2p_pkg::PC_HDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         left_ff      <= left_in;
         open_ff      <= open_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      cnt_ff    <= cnt_in;
      dig_ff    <= dig_in;
      lead_ff   <= lead_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      done_ff   <= done_in;
   end

endmodule
